>>> hdl/pfcw_pkg.sv
// ----------------------------------------------------------------------------
// pfcw_pkg: shared types and constants of the PFC pause and watermark control
// Field widths, opcodes, register indexes and the item, result and
// configuration records used across the block.
// ----------------------------------------------------------------------------
package pfcw_pkg;

  // Sizing of the per-class state
  localparam int NUM_CLASSES = 8;
  localparam int COUNT_BITS  = 10;
  localparam int CLASS_BITS  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

  // Fixed field widths
  localparam int OPCODE_BITS = 3;
  localparam int PRIO_BITS   = 3;
  localparam int QUANTA_BITS = 16;
  localparam int MASK_BITS   = 8;
  localparam int WM_BITS     = 10;
  localparam int CMP_BITS    = (COUNT_BITS > WM_BITS) ? COUNT_BITS : WM_BITS;

  // Configuration port
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic [CFG_INDEX_BITS-1:0] REG_PFC_ENABLE     = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_HIGH_WATERMARK = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LOW_WATERMARK  = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_XOFF_QUANTA    = 2'd3;

  // Item kinds
  localparam logic [OPCODE_BITS-1:0] OP_ARRIVAL = 3'd0;
  localparam logic [OPCODE_BITS-1:0] OP_DRAIN   = 3'd1;
  localparam logic [OPCODE_BITS-1:0] OP_PAUSE   = 3'd2;
  localparam logic [OPCODE_BITS-1:0] OP_TICK    = 3'd3;
  localparam logic [OPCODE_BITS-1:0] OP_EGRESS  = 3'd4;

  typedef logic [COUNT_BITS-1:0]  count_t;
  typedef logic [QUANTA_BITS-1:0] quanta_t;
  typedef logic [CLASS_BITS-1:0]  class_t;
  typedef logic [WM_BITS-1:0]     wm_t;

  localparam count_t COUNT_MAX = '1;

  typedef struct packed {
    logic [OPCODE_BITS-1:0] opcode;
    logic [PRIO_BITS-1:0]   prio;
    quanta_t                pause_quanta;
    logic                   drain_allowed;
    logic [MASK_BITS-1:0]   egress_nonempty;
  } item_t;

  typedef struct packed {
    logic                 send_xoff;
    logic                 send_xon;
    logic [PRIO_BITS-1:0] frame_class;
    quanta_t              frame_quanta;
    logic                 drained_valid;
    logic [PRIO_BITS-1:0] drained_class;
    logic                 egress_valid;
    logic [PRIO_BITS-1:0] egress_class;
    logic [MASK_BITS-1:0] paused_mask;
  } result_t;

  typedef struct packed {
    logic    pfc_enable;
    wm_t     high_watermark;
    wm_t     low_watermark;
    quanta_t xoff_quanta;
  } cfg_t;

endpackage

>>> hdl/pfcw_item_if.sv
// ----------------------------------------------------------------------------
// pfcw_item_if: input item channel
// Valid/ready channel carrying one control or data event per transaction.
// ----------------------------------------------------------------------------
interface pfcw_item_if import pfcw_pkg::*; ();
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hdl/pfcw_result_if.sv
// ----------------------------------------------------------------------------
// pfcw_result_if: result channel
// Valid/ready channel carrying one result record per transaction.
// ----------------------------------------------------------------------------
interface pfcw_result_if import pfcw_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hdl/pfcw_core.sv
// ----------------------------------------------------------------------------
// pfcw_core: per-class state and single-pass update
// Holds counts, occupancy, hysteresis flags and pause timers of every class,
// and works out the result and the next state of one registered item.
// ----------------------------------------------------------------------------
module pfcw_core import pfcw_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t result
);

  count_t                 ingress_count [NUM_CLASSES];
  count_t                 occupancy     [NUM_CLASSES];
  quanta_t                pause_remaining [NUM_CLASSES];
  logic [NUM_CLASSES-1:0] congested;
  logic [NUM_CLASSES-1:0] paused;

  count_t                 ingress_count_next [NUM_CLASSES];
  count_t                 occupancy_next     [NUM_CLASSES];
  quanta_t                pause_remaining_next [NUM_CLASSES];
  logic [NUM_CLASSES-1:0] congested_next;
  logic [NUM_CLASSES-1:0] paused_next;

  // Work out the next state and the result of the current item
  always_comb begin
    class_t  cls;
    logic    in_range;
    count_t  occ_inc;
    count_t  occ_dec;
    logic    xoff;
    logic    cong_mid;
    logic    xon;
    logic    pick_found;
    class_t  pick;
    quanta_t rem_dec;

    ingress_count_next   = ingress_count;
    occupancy_next       = occupancy;
    pause_remaining_next = pause_remaining;
    congested_next       = congested;
    paused_next          = paused;
    result               = '0;

    cls      = class_t'(item.prio);
    in_range = int'(item.prio) < NUM_CLASSES;
    occ_inc  = '0;
    occ_dec  = '0;
    xoff     = 1'b0;
    cong_mid = 1'b0;
    xon      = 1'b0;
    rem_dec  = '0;

    // Highest class with a non-zero ingress count
    pick_found = 1'b0;
    pick       = '0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (ingress_count[c] != '0) begin
        pick_found = 1'b1;
        pick       = class_t'(c);
      end
    end

    case (item.opcode)
      OP_ARRIVAL: begin
        if (in_range) begin
          if (ingress_count[cls] != COUNT_MAX) begin
            ingress_count_next[cls] = ingress_count[cls] + count_t'(1);
          end
          if (cfg.pfc_enable) begin
            occ_inc = (occupancy[cls] != COUNT_MAX) ? occupancy[cls] + count_t'(1)
                                                    : occupancy[cls];
            occupancy_next[cls] = occ_inc;
            xoff = !congested[cls] &&
                   (CMP_BITS'(occ_inc) >= CMP_BITS'(cfg.high_watermark));
            cong_mid = congested[cls] | xoff;
            xon = cong_mid && (CMP_BITS'(occ_inc) <= CMP_BITS'(cfg.low_watermark));
            congested_next[cls] = cong_mid & ~xon;
            result.send_xoff    = xoff;
            result.send_xon     = xon;
            result.frame_class  = (xoff || xon) ? PRIO_BITS'(cls) : '0;
            result.frame_quanta = xoff ? cfg.xoff_quanta : '0;
          end
        end
      end
      OP_DRAIN: begin
        if (pick_found && item.drain_allowed) begin
          ingress_count_next[pick] = ingress_count[pick] - count_t'(1);
          occ_dec = (occupancy[pick] != '0) ? occupancy[pick] - count_t'(1) : '0;
          occupancy_next[pick] = occ_dec;
          result.drained_valid = 1'b1;
          result.drained_class = PRIO_BITS'(pick);
          xon = cfg.pfc_enable && congested[pick] &&
                (CMP_BITS'(occ_dec) <= CMP_BITS'(cfg.low_watermark));
          if (xon) begin
            congested_next[pick] = 1'b0;
            result.send_xon      = 1'b1;
            result.frame_class   = PRIO_BITS'(pick);
          end
        end
      end
      OP_PAUSE: begin
        if (in_range) begin
          paused_next[cls]          = item.pause_quanta != '0;
          pause_remaining_next[cls] = item.pause_quanta;
        end
      end
      OP_TICK: begin
        // Count every running timer down; resume at zero
        for (int c = 0; c < NUM_CLASSES; c++) begin
          if (paused[c]) begin
            rem_dec = (pause_remaining[c] != '0) ? pause_remaining[c] - quanta_t'(1) : '0;
            pause_remaining_next[c] = rem_dec;
            if (rem_dec == '0) begin
              paused_next[c] = 1'b0;
            end
          end
        end
      end
      OP_EGRESS: begin
        // Strict priority: the last match in ascending order wins
        for (int c = 0; c < NUM_CLASSES; c++) begin
          if (item.egress_nonempty[c] && !paused[c]) begin
            result.egress_valid = 1'b1;
            result.egress_class = PRIO_BITS'(c);
          end
        end
      end
      default: begin
      end
    endcase

    for (int c = 0; c < NUM_CLASSES; c++) begin
      result.paused_mask[c] = paused_next[c];
    end
  end

  // Commit the state of each class when an item completes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        ingress_count[c]   <= '0;
        occupancy[c]       <= '0;
        pause_remaining[c] <= '0;
      end
      congested <= '0;
      paused    <= '0;
    end else if (fire) begin
      ingress_count   <= ingress_count_next;
      occupancy       <= occupancy_next;
      pause_remaining <= pause_remaining_next;
      congested       <= congested_next;
      paused          <= paused_next;
    end
  end

endmodule

>>> hdl/pfcw_out_reg.sv
// ----------------------------------------------------------------------------
// pfcw_out_reg: result register
// Holds one finished result until the downstream side takes it, and tells
// the core when a new result may be loaded.
// ----------------------------------------------------------------------------
module pfcw_out_reg import pfcw_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t data,
  output logic    can_load,
  pfcw_result_if.source results
);

  logic    valid;
  result_t held;

  assign can_load      = !valid || results.ready;
  assign results.valid = valid;
  assign results.data  = held;

  // Load a new result or drop the one just taken
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (can_load) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      held <= data;
    end
  end

endmodule

>>> hdl/pfc_pause_and_watermark_ctrl.sv
// ----------------------------------------------------------------------------
// pfc_pause_and_watermark_ctrl: priority flow control pause and watermark unit
// Eight-class PFC controller: watermark XOFF/XON generation with hysteresis,
// ingress drain selection, pause timers and strict-priority egress selection.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle and returns exactly one result per
// item, in order. The result is offered on the result channel once the item
// has moved from the input register into the result register. The item is
// held in an input register, the whole per-class update is one pass of logic
// into the result register, and the class state is written at the same edge,
// so the next item already sees it. The result register lets a new item enter
// while a result waits; throughput falls below one per cycle only while the
// result channel is stalled. Configuration is written through cfg_wen,
// cfg_index and cfg_data, one register per cycle, and the user must write it
// only while no item is in flight; the block itself does not enforce this.
module pfc_pause_and_watermark_ctrl import pfcw_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wen,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  pfcw_item_if.sink                 items,
  pfcw_result_if.source             results
);

  cfg_t    cfg;
  logic    s1_valid;
  item_t   s1_item;
  logic    can_load;
  logic    advance;
  result_t core_result;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pfc_enable     <= 1'b1;
      cfg.high_watermark <= wm_t'(8);
      cfg.low_watermark  <= wm_t'(4);
      cfg.xoff_quanta    <= '1;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_PFC_ENABLE:     cfg.pfc_enable     <= cfg_data[0];
        REG_HIGH_WATERMARK: cfg.high_watermark <= cfg_data[WM_BITS-1:0];
        REG_LOW_WATERMARK:  cfg.low_watermark  <= cfg_data[WM_BITS-1:0];
        REG_XOFF_QUANTA:    cfg.xoff_quanta    <= cfg_data[QUANTA_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input register: advance when the result register can take the result
  assign advance     = s1_valid && can_load;
  assign items.ready = !s1_valid || can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (items.valid && items.ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      s1_item <= items.data;
    end
  end

  pfcw_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (s1_item),
    .cfg    (cfg),
    .result (core_result)
  );

  pfcw_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (advance),
    .data     (core_result),
    .can_load (can_load),
    .results  (results)
  );

  // An item that leaves the input register shows up as a result
  a_advance_gives_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> results.valid)
    else $error("completed item did not produce a result");

  // The input side only stalls while an item is held
  a_stall_only_when_held: assert property (@(posedge clk) disable iff (rst)
    !items.ready |-> s1_valid)
    else $error("input stalled with an empty input register");

  // A drain never comes with an egress choice or an XOFF frame from the same item
  a_one_kind_per_result: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> !(results.data.drained_valid && results.data.egress_valid)
                      && !(results.data.send_xoff && results.data.drained_valid))
    else $error("result mixes fields of different item kinds");

  // The chosen egress class is never a paused one
  a_egress_not_paused: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.data.egress_valid
      |-> !results.data.paused_mask[results.data.egress_class])
    else $error("egress selected a paused class");

endmodule

>>> sim/pfc_pause_and_watermark_ctrl_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pfc_pause_and_watermark_ctrl_tb: self-checking bench for the PFC controller
// Runs a table of directed events at reset and two hand-picked settings, a
// counter saturation burst, then random events over several watermark and
// enable settings. Every result is checked against a cycle-free model of the
// per-class occupancy, hysteresis, pause timers and priority selection.
// Both channels idle at random, and the result side holds off once at length.
// ----------------------------------------------------------------------------
module pfc_pause_and_watermark_ctrl_tb;
  import pfcw_pkg::*;

  // Item kinds the block must ignore
  localparam logic [OPCODE_BITS-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [OPCODE_BITS-1:0] OP_SPARE_LAST  = 3'd7;

  localparam int unsigned CYCLE_LIMIT      = 1000000;
  localparam int unsigned SETTLE_CYCLES    = 4;
  localparam int unsigned SQUEEZE_AT       = 600;
  localparam int unsigned HOLD_OFF_CYCLES  = 400;
  localparam int unsigned PHASES           = 7;
  localparam int unsigned EVENTS_PER_PHASE = 100;
  localparam int unsigned SAT_CLASS        = 1;

  typedef struct {
    bit      cfg_change;
    cfg_t    cfg;
    item_t   stim;
    bit      typed;
    result_t want;
  } vector_t;

  logic clk;
  logic rst;
  logic cfg_wen;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  pfcw_item_if   item_ch ();
  pfcw_result_if result_ch ();

  pfc_pause_and_watermark_ctrl dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .items     (item_ch),
    .results   (result_ch)
  );

  // Model state of the controller
  count_t  cls_ingress    [NUM_CLASSES];
  count_t  cls_occupancy  [NUM_CLASSES];
  quanta_t cls_pause_left [NUM_CLASSES];
  logic [NUM_CLASSES-1:0] cls_congested;
  logic [NUM_CLASSES-1:0] cls_paused;
  cfg_t    pfc_cfg;

  result_t     pending_results [$];
  vector_t     directed [$];
  int unsigned mismatch_count = 0;
  int unsigned results_seen   = 0;
  int unsigned cycle_count    = 0;
  bit          no_idle        = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic cfg_t cfg_of(logic en, wm_t hw, wm_t lw, quanta_t xq);
    return cfg_t'({en, hw, lw, xq});
  endfunction

  function automatic item_t ev_of(logic [OPCODE_BITS-1:0] op, logic [PRIO_BITS-1:0] prio,
                                  quanta_t pq, logic allow, logic [MASK_BITS-1:0] nonempty);
    return item_t'({op, prio, pq, allow, nonempty});
  endfunction

  function automatic result_t res_of(logic xoff, logic xon, logic [PRIO_BITS-1:0] fc,
                                     quanta_t fq, logic dv, logic [PRIO_BITS-1:0] dc,
                                     logic egv, logic [PRIO_BITS-1:0] ec,
                                     logic [MASK_BITS-1:0] mask);
    return result_t'({xoff, xon, fc, fq, dv, dc, egv, ec, mask});
  endfunction

  // Apply one event to the model state and return the result it produces
  function automatic result_t predict_pfc_result(item_t it);
    result_t r;
    int      p;
    int      pick;
    int      c;
    r = '0;
    p = int'(it.prio);
    pick = -1;
    case (it.opcode)
      OP_ARRIVAL: begin
        if (p < NUM_CLASSES) begin
          if (cls_ingress[p] != COUNT_MAX) cls_ingress[p]++;
          if (pfc_cfg.pfc_enable) begin
            if (cls_occupancy[p] != COUNT_MAX) cls_occupancy[p]++;
            // XOFF on first reaching the high mark, XON may follow at once
            if (!cls_congested[p] && cls_occupancy[p] >= pfc_cfg.high_watermark) begin
              cls_congested[p] = 1'b1;
              r.send_xoff      = 1'b1;
              r.frame_class    = PRIO_BITS'(p);
              r.frame_quanta   = pfc_cfg.xoff_quanta;
            end
            if (cls_congested[p] && cls_occupancy[p] <= pfc_cfg.low_watermark) begin
              cls_congested[p] = 1'b0;
              r.send_xon       = 1'b1;
              r.frame_class    = PRIO_BITS'(p);
            end
          end
        end
      end
      OP_DRAIN: begin
        for (c = NUM_CLASSES - 1; c >= 0; c--)
          if (pick < 0 && cls_ingress[c] != 0) pick = c;
        if (pick >= 0 && it.drain_allowed) begin
          cls_ingress[pick]--;
          if (cls_occupancy[pick] != 0) cls_occupancy[pick]--;
          r.drained_valid = 1'b1;
          r.drained_class = PRIO_BITS'(pick);
          if (pfc_cfg.pfc_enable && cls_congested[pick] &&
              cls_occupancy[pick] <= pfc_cfg.low_watermark) begin
            cls_congested[pick] = 1'b0;
            r.send_xon          = 1'b1;
            r.frame_class       = PRIO_BITS'(pick);
          end
        end
      end
      OP_PAUSE: begin
        if (p < NUM_CLASSES) begin
          cls_paused[p]     = (it.pause_quanta != 0);
          cls_pause_left[p] = it.pause_quanta;
        end
      end
      OP_TICK: begin
        for (c = 0; c < NUM_CLASSES; c++) begin
          if (cls_paused[c]) begin
            if (cls_pause_left[c] != 0) cls_pause_left[c]--;
            if (cls_pause_left[c] == 0) cls_paused[c] = 1'b0;
          end
        end
      end
      OP_EGRESS: begin
        for (c = NUM_CLASSES - 1; c >= 0; c--) begin
          if (!r.egress_valid && it.egress_nonempty[c] && !cls_paused[c]) begin
            r.egress_valid = 1'b1;
            r.egress_class = PRIO_BITS'(c);
          end
        end
      end
      default: ;
    endcase
    for (c = 0; c < NUM_CLASSES; c++) r.paused_mask[c] = cls_paused[c];
    return r;
  endfunction

  // Mostly no gap, sometimes a short one, rarely a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic item_t random_event();
    item_t       ev;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 32)      ev.opcode = OP_ARRIVAL;
    else if (r < 62) ev.opcode = OP_DRAIN;
    else if (r < 72) ev.opcode = OP_PAUSE;
    else if (r < 86) ev.opcode = OP_TICK;
    else if (r < 97) ev.opcode = OP_EGRESS;
    else             ev.opcode = OPCODE_BITS'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
    ev.prio = PRIO_BITS'($urandom_range(0, NUM_CLASSES - 1));
    // Short pauses expire under ticks, long ones need an explicit resume
    r = $urandom_range(0, 9);
    if (r < 5)      ev.pause_quanta = quanta_t'($urandom_range(1, 6));
    else if (r < 7) ev.pause_quanta = '0;
    else if (r < 8) ev.pause_quanta = '1;
    else            ev.pause_quanta = quanta_t'($urandom);
    ev.drain_allowed   = ($urandom_range(0, 7) != 0);
    ev.egress_nonempty = MASK_BITS'($urandom);
    return ev;
  endfunction

  task automatic stim_row(item_t stim, bit typed, result_t want);
    vector_t v;
    v.cfg_change = 1'b0;
    v.cfg        = '0;
    v.stim       = stim;
    v.typed      = typed;
    v.want       = want;
    directed.insert(directed.size(), v);
  endtask

  task automatic cfg_row(cfg_t c);
    vector_t v;
    v.cfg_change = 1'b1;
    v.cfg        = c;
    v.stim       = '0;
    v.typed      = 1'b0;
    v.want       = '0;
    directed.insert(directed.size(), v);
  endtask

  // Offer one event, hold it until accepted, then record what it must produce
  task automatic offer_event(item_t ev, bit typed, result_t want);
    int unsigned gap;
    result_t     model;
    gap = idle_len();
    if (gap != 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.data  <= ev;
    do @(posedge clk); while (item_ch.ready !== 1'b1);
    model = predict_pfc_result(ev);
    pending_results.insert(pending_results.size(), typed ? want : model);
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // Let the block go idle, then rewrite every register
  task automatic load_pfc_config(cfg_t c);
    item_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_PFC_ENABLE,     CFG_DATA_BITS'(c.pfc_enable));
    write_reg(REG_HIGH_WATERMARK, CFG_DATA_BITS'(c.high_watermark));
    write_reg(REG_LOW_WATERMARK,  CFG_DATA_BITS'(c.low_watermark));
    write_reg(REG_XOFF_QUANTA,    CFG_DATA_BITS'(c.xoff_quanta));
    cfg_wen <= 1'b0;
    pfc_cfg = c;
  endtask

  task automatic check_field(string field, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatch_count++;
    end
  endtask

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result transaction with none expected: %h", result_ch.data);
        mismatch_count++;
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        check_field("send_xoff",     want.send_xoff,     result_ch.data.send_xoff);
        check_field("send_xon",      want.send_xon,      result_ch.data.send_xon);
        check_field("frame_class",   want.frame_class,   result_ch.data.frame_class);
        check_field("frame_quanta",  want.frame_quanta,  result_ch.data.frame_quanta);
        check_field("drained_valid", want.drained_valid, result_ch.data.drained_valid);
        check_field("drained_class", want.drained_class, result_ch.data.drained_class);
        check_field("egress_valid",  want.egress_valid,  result_ch.data.egress_valid);
        check_field("egress_class",  want.egress_class,  result_ch.data.egress_class);
        check_field("paused_mask",   want.paused_mask,   result_ch.data.paused_mask);
      end
    end
  end

  // Result side: random stalls, plus one long hold-off to back the block up
  initial begin : result_sink
    int unsigned stall;
    bit          squeezed;
    squeezed = 1'b0;
    result_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!squeezed && results_seen >= SQUEEZE_AT) begin
        squeezed = 1'b1;
        result_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      stall = idle_len();
      if (stall != 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    cfg_t phase_cfg [PHASES];
    int   hw;
    int   lw;

    rst           <= 1'b1;
    cfg_wen       <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    item_ch.valid <= 1'b0;
    item_ch.data  <= '0;
    foreach (cls_ingress[c]) begin
      cls_ingress[c]    = '0;
      cls_occupancy[c]  = '0;
      cls_pause_left[c] = '0;
    end
    cls_congested = '0;
    cls_paused    = '0;
    pfc_cfg       = cfg_of(1'b1, 10'd8, 10'd4, 16'hFFFF);

    // Selection and pause handling from reset
    stim_row(ev_of(OP_EGRESS, 3'd0, 16'd0, 1'b0, 8'hFF), 1,
             res_of(0, 0, 3'd0, 16'd0, 0, 3'd0, 1, 3'd7, 8'h00));
    stim_row(ev_of(OP_EGRESS, 3'd0, 16'd0, 1'b0, 8'h00), 1, '0);
    stim_row(ev_of(OP_DRAIN, 3'd0, 16'd0, 1'b1, 8'h00), 1, '0);
    stim_row(ev_of(OP_PAUSE, 3'd7, 16'hFFFF, 1'b0, 8'h00), 1,
             res_of(0, 0, 3'd0, 16'd0, 0, 3'd0, 0, 3'd0, 8'h80));
    stim_row(ev_of(OP_PAUSE, 3'd0, 16'd1, 1'b0, 8'h00), 1,
             res_of(0, 0, 3'd0, 16'd0, 0, 3'd0, 0, 3'd0, 8'h81));
    stim_row(ev_of(OP_EGRESS, 3'd0, 16'd0, 1'b0, 8'hFF), 1,
             res_of(0, 0, 3'd0, 16'd0, 0, 3'd0, 1, 3'd6, 8'h81));
    stim_row(ev_of(OP_EGRESS, 3'd0, 16'd0, 1'b0, 8'h81), 1,
             res_of(0, 0, 3'd0, 16'd0, 0, 3'd0, 0, 3'd0, 8'h81));
    stim_row(ev_of(OP_TICK, 3'd0, 16'd0, 1'b0, 8'h00), 1,
             res_of(0, 0, 3'd0, 16'd0, 0, 3'd0, 0, 3'd0, 8'h80));
    stim_row(ev_of(OP_PAUSE, 3'd7, 16'd0, 1'b0, 8'h00), 1, '0);
    stim_row(ev_of(OP_SPARE_FIRST, 3'd7, 16'hFFFF, 1'b1, 8'hFF), 1, '0);
    // Fill class 3 up to the high mark, then drain it down to the low mark
    repeat (7) stim_row(ev_of(OP_ARRIVAL, 3'd3, 16'd0, 1'b0, 8'h00), 0, '0);
    stim_row(ev_of(OP_ARRIVAL, 3'd3, 16'd0, 1'b0, 8'h00), 1,
             res_of(1, 0, 3'd3, 16'hFFFF, 0, 3'd0, 0, 3'd0, 8'h00));
    stim_row(ev_of(OP_DRAIN, 3'd0, 16'd0, 1'b0, 8'h00), 1, '0);
    repeat (3) stim_row(ev_of(OP_DRAIN, 3'd0, 16'd0, 1'b1, 8'h00), 0, '0);
    stim_row(ev_of(OP_DRAIN, 3'd0, 16'd0, 1'b1, 8'h00), 1,
             res_of(0, 1, 3'd3, 16'd0, 1, 3'd3, 0, 3'd0, 8'h00));
    // Overlapping watermarks send both frames on one arrival
    cfg_row(cfg_of(1'b1, 10'd2, 10'd5, 16'h1234));
    stim_row(ev_of(OP_ARRIVAL, 3'd5, 16'd0, 1'b0, 8'h00), 0, '0);
    stim_row(ev_of(OP_ARRIVAL, 3'd5, 16'd0, 1'b0, 8'h00), 1,
             res_of(1, 1, 3'd5, 16'h1234, 0, 3'd0, 0, 3'd0, 8'h00));
    // Disabled: arrival only counts, drain takes it without any frame
    cfg_row(cfg_of(1'b0, 10'd2, 10'd5, 16'h0000));
    stim_row(ev_of(OP_ARRIVAL, 3'd6, 16'd0, 1'b0, 8'h00), 0, '0);
    stim_row(ev_of(OP_DRAIN, 3'd0, 16'd0, 1'b1, 8'h00), 1,
             res_of(0, 0, 3'd0, 16'd0, 1, 3'd6, 0, 3'd0, 8'h00));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      if (directed[i].cfg_change) load_pfc_config(directed[i].cfg);
      else offer_event(directed[i].stim, directed[i].typed, directed[i].want);
    end

    // Drive one class past saturation with the highest mark
    load_pfc_config(cfg_of(1'b1, 10'd1023, 10'd0, 16'hFFFF));
    repeat (int'(COUNT_MAX) + 8)
      offer_event(ev_of(OP_ARRIVAL, PRIO_BITS'(SAT_CLASS), quanta_t'($urandom), 1'b1,
                        MASK_BITS'($urandom)), 1'b0, '0);

    // Random traffic over a spread of settings, extremes included
    hw = $urandom_range(1, 12);
    lw = $urandom_range(0, hw);
    phase_cfg[0] = cfg_of(1'b1, 10'd6, 10'd2, quanta_t'($urandom));
    phase_cfg[1] = cfg_of(1'b0, 10'd3, 10'd1, 16'h0000);
    phase_cfg[2] = cfg_of(1'b1, 10'd0, 10'd0, 16'hFFFF);
    phase_cfg[3] = cfg_of(1'b1, 10'd3, 10'd5, quanta_t'($urandom));
    phase_cfg[4] = cfg_of(1'b1, 10'd1023, 10'd1023, 16'h8001);
    phase_cfg[5] = cfg_of(1'b1, wm_t'(hw), wm_t'(lw), quanta_t'($urandom));
    phase_cfg[6] = cfg_of(1'b1, 10'd1, 10'd0, 16'h7FFE);
    for (int ph = 0; ph < PHASES; ph++) begin
      load_pfc_config(phase_cfg[ph]);
      no_idle = ($urandom_range(0, 3) == 0);
      repeat (EVENTS_PER_PHASE) offer_event(random_event(), 1'b0, '0);
    end

    // Wait out the tail, then report
    item_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
